@@ hdl/dq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Operation, error and state codes shared by the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH_RIGHT = 2'd0,
    MODE_POP_LEFT   = 2'd1,
    MODE_POP_RIGHT  = 2'd2,
    MODE_NOP        = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef enum logic {
    SIDE_LEFT  = 1'b0,
    SIDE_RIGHT = 1'b1
  } side_e;

endpackage
`default_nettype wire

@@ hdl/double_ended_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of DEPTH items held in a circular buffer memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one operation item:
//   mode_i selects push right, pop left, pop right or no operation, and
//   value_i is the item to push. Output channel (out_valid_o / out_ready_i)
//   returns exactly one result item per operation: popped value, error code,
//   left and right items, empty flag and item count after the operation.
//   The left and right items are kept in registers beside the slot memory,
//   so a push or a no operation needs no slot fetch. A pop that leaves two
//   or more items must fetch the new end item from the slot memory, whose
//   synchronous read is waited for in the ST_READ state before the result.
//   One operation is in flight at a time; the next item is taken once its
//   result is registered and the output register is free or being drained.
//   Reset empties the queue (left index and count go to zero); slot memory
//   contents are left as they are and never show. When the receiver stalls,
//   the result holds in the output register and in_ready_o stays low.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic [ITEM_WIDTH-1:0] value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [ITEM_WIDTH-1:0]      popped_value_o,
  output logic [1:0]                 error_o,
  output logic [ITEM_WIDTH-1:0]      left_item_o,
  output logic [ITEM_WIDTH-1:0]      right_item_o,
  output logic                       is_empty_o,
  output logic [CNT_W-1:0]           item_count_o
);

  localparam logic [IDX_W:0] DepthX = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH);

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
    logic [IDX_W:0] t;
    t = (s >= DepthX) ? (s - DepthX) : s;
    return t[IDX_W-1:0];
  endfunction

  // slot memory
  logic [ITEM_WIDTH-1:0] mem_q [DEPTH];
  logic [ITEM_WIDTH-1:0] rd_data_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;

  state_e state_q, state_d;
  side_e  side_q, side_d;
  logic [IDX_W-1:0]      left_idx_q, left_idx_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ITEM_WIDTH-1:0] left_q, left_d;
  logic [ITEM_WIDTH-1:0] right_q, right_d;
  logic [ITEM_WIDTH-1:0] pend_pop_q, pend_pop_d;

  logic                  out_valid_q, out_valid_d;
  logic [ITEM_WIDTH-1:0] out_pop_q, out_pop_d;
  err_e                  out_err_q, out_err_d;
  logic [ITEM_WIDTH-1:0] out_left_q, out_left_d;
  logic [ITEM_WIDTH-1:0] out_right_q, out_right_d;
  logic                  out_empty_q, out_empty_d;
  logic [CNT_W-1:0]      out_count_q, out_count_d;

  logic                  accept;
  logic                  need_read;
  logic                  emit;
  logic [ITEM_WIDTH-1:0] res_pop;
  err_e                  res_err;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Datapath: operate on the cached ends, write or fetch one slot.
  always_comb begin
    left_idx_d = left_idx_q;
    count_d    = count_q;
    left_d     = left_q;
    right_d    = right_q;
    pend_pop_d = pend_pop_q;
    side_d     = side_q;
    mem_we     = 1'b0;
    mem_waddr  = wrap_idx({1'b0, left_idx_q} + (IDX_W + 1)'(count_q));
    rd_en      = 1'b0;
    rd_addr    = '0;
    need_read  = 1'b0;
    emit       = 1'b0;
    res_pop    = '0;
    res_err    = ERR_OK;

    if (state_q == ST_READ) begin
      if (side_q == SIDE_LEFT) begin
        left_d = rd_data_q;
      end else begin
        right_d = rd_data_q;
      end
      res_pop = pend_pop_q;
      emit    = 1'b1;
    end else if (accept) begin
      unique case (mode_e'(mode_i))
        MODE_PUSH_RIGHT: begin
          if (count_q == DepthC) begin
            res_err = ERR_FULL;
          end else begin
            mem_we  = 1'b1;
            right_d = value_i;
            if (count_q == '0) begin
              left_d = value_i;
            end
            count_d = count_q + CNT_W'(1);
          end
        end
        MODE_POP_LEFT: begin
          if (count_q == '0) begin
            res_err = ERR_EMPTY;
          end else begin
            res_pop    = left_q;
            left_idx_d = wrap_idx({1'b0, left_idx_q} + (IDX_W + 1)'(1));
            count_d    = count_q - CNT_W'(1);
            if (count_q > CNT_W'(2)) begin
              rd_en  = 1'b1;
              rd_addr = left_idx_d;
              side_d = SIDE_LEFT;
              need_read = 1'b1;
            end else begin
              left_d = right_q;
            end
          end
        end
        MODE_POP_RIGHT: begin
          if (count_q == '0) begin
            res_err = ERR_EMPTY;
          end else begin
            res_pop = right_q;
            count_d = count_q - CNT_W'(1);
            if (count_q > CNT_W'(2)) begin
              rd_en   = 1'b1;
              rd_addr = wrap_idx({1'b0, left_idx_q} + (IDX_W + 1)'(count_q)
                                 - (IDX_W + 1)'(2));
              side_d  = SIDE_RIGHT;
              need_read = 1'b1;
            end else begin
              right_d = left_q;
            end
          end
        end
        MODE_NOP: begin
        end
        default: begin
        end
      endcase
      pend_pop_d = res_pop;
      emit       = !need_read;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && need_read) state_d = ST_READ;
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Result register load
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_pop_d   = out_pop_q;
    out_err_d   = out_err_q;
    out_left_d  = out_left_q;
    out_right_d = out_right_q;
    out_empty_d = out_empty_q;
    out_count_d = out_count_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_pop_d   = res_pop;
      out_err_d   = res_err;
      out_empty_d = (count_d == '0);
      out_count_d = count_d;
      out_left_d  = (count_d == '0) ? '0 : left_d;
      out_right_d = (count_d == '0) ? '0 : right_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_idx_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_idx_q  <= left_idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q      <= side_d;
    left_q      <= left_d;
    right_q     <= right_d;
    pend_pop_q  <= pend_pop_d;
    out_pop_q   <= out_pop_d;
    out_err_q   <= out_err_d;
    out_left_q  <= out_left_d;
    out_right_q <= out_right_d;
    out_empty_q <= out_empty_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_pop_q;
  assign error_o        = out_err_q;
  assign left_item_o    = out_left_q;
  assign right_item_o   = out_right_q;
  assign is_empty_o     = out_empty_q;
  assign item_count_o   = out_count_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("held count exceeds depth");

  a_read_needs_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (count_q >= CNT_W'(2)))
    else $error("slot fetch with fewer than two items held");

  a_read_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !out_valid_q)
    else $error("result register busy during slot fetch");

  a_read_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("slot fetch did not deliver a result");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == ST_IDLE))
    else $error("item taken while a fetch is pending");

endmodule
`default_nettype wire

@@ tb/double_ended_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded deque. A scoreboard predicts the result
// of every accepted operation and checks each delivered result in order. The
// sender runs in bursts, and the receiver stalls on its own pattern,
// including one long hold-off that backs up the input channel.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int ITEM_WIDTH  = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int NUM_RANDOM  = 1850;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_START  = 1500;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [ITEM_WIDTH-1:0] popped_value;
    logic [1:0]            error;
    logic [ITEM_WIDTH-1:0] left_item;
    logic [ITEM_WIDTH-1:0] right_item;
    logic                  is_empty;
    logic [CNT_W-1:0]      item_count;
  } dq_result_t;

  class deque_scoreboard;
    logic [ITEM_WIDTH-1:0] slot_mem [DEPTH];
    bit [3:0]              left_idx;
    bit [CNT_W-1:0]        held;
    dq_result_t            pending [$];
    int                    mismatches;

    function new();
      left_idx   = '0;
      held       = '0;
      mismatches = 0;
    endfunction

    // Apply one accepted operation to the shadow deque and queue its result.
    function void note_op(mode_e op, logic [ITEM_WIDTH-1:0] value);
      dq_result_t exp;
      bit [3:0]   idx;
      exp.popped_value = '0;
      exp.error        = ERR_OK;
      case (op)
        MODE_PUSH_RIGHT: begin
          if (held == DEPTH) begin
            exp.error = ERR_FULL;
          end else begin
            idx = left_idx + held[3:0];
            slot_mem[idx] = value;
            held++;
          end
        end
        MODE_POP_LEFT: begin
          if (held == 0) begin
            exp.error = ERR_EMPTY;
          end else begin
            exp.popped_value = slot_mem[left_idx];
            left_idx++;
            held--;
          end
        end
        MODE_POP_RIGHT: begin
          if (held == 0) begin
            exp.error = ERR_EMPTY;
          end else begin
            idx = left_idx + held[3:0] - 4'd1;
            exp.popped_value = slot_mem[idx];
            held--;
          end
        end
        default: begin
        end
      endcase
      if (held == 0) begin
        exp.left_item  = '0;
        exp.right_item = '0;
        exp.is_empty   = 1'b1;
      end else begin
        idx            = left_idx + held[3:0] - 4'd1;
        exp.left_item  = slot_mem[left_idx];
        exp.right_item = slot_mem[idx];
        exp.is_empty   = 1'b0;
      end
      exp.item_count = held;
      pending.insert(pending.size(), exp);
    endfunction

    function void compare_field(string name, logic [ITEM_WIDTH-1:0] exp_v,
                                logic [ITEM_WIDTH-1:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(dq_result_t got);
      dq_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: result with no operation outstanding: popped %h count %0d",
                 $time, got.popped_value, got.item_count);
        mismatches++;
      end else begin
        exp = pending.pop_front();
        compare_field("popped_value", exp.popped_value, got.popped_value);
        compare_field("error", ITEM_WIDTH'(exp.error), ITEM_WIDTH'(got.error));
        compare_field("left_item", exp.left_item, got.left_item);
        compare_field("right_item", exp.right_item, got.right_item);
        compare_field("is_empty", ITEM_WIDTH'(exp.is_empty), ITEM_WIDTH'(got.is_empty));
        compare_field("item_count", ITEM_WIDTH'(exp.item_count), ITEM_WIDTH'(got.item_count));
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            mode_i;
  logic [ITEM_WIDTH-1:0] value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [ITEM_WIDTH-1:0] popped_value_o;
  logic [1:0]            error_o;
  logic [ITEM_WIDTH-1:0] left_item_o;
  logic [ITEM_WIDTH-1:0] right_item_o;
  logic                  is_empty_o;
  logic [CNT_W-1:0]      item_count_o;

  deque_scoreboard sb;
  dq_result_t      observed;
  int              idle_cycles;

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_o (popped_value_o),
    .error_o        (error_o),
    .left_item_o    (left_item_o),
    .right_item_o   (right_item_o),
    .is_empty_o     (is_empty_o),
    .item_count_o   (item_count_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sample both channels at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_op(mode_e'(mode_i), value_i);
      end
      if (out_valid_o && out_ready_i) begin
        observed.popped_value = popped_value_o;
        observed.error        = error_o;
        observed.left_item    = left_item_o;
        observed.right_item   = right_item_o;
        observed.is_empty     = is_empty_o;
        observed.item_count   = item_count_o;
        sb.check_result(observed);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stall pattern is re-picked at random from four; one long hold-off.
  initial begin
    int rx_cycle;
    int pattern;
    bit hold_done;
    rx_cycle  = 0;
    pattern   = 0;
    hold_done = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (!hold_done && rx_cycle >= HOLD_START) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      if (rx_cycle % 64 == 0) pattern = $urandom_range(0, 3);
      case (pattern)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 1) == 0);
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Hold the item until the block takes it, then return at a falling edge.
  task automatic offer_item(mode_e op, logic [ITEM_WIDTH-1:0] value);
    in_valid_i <= 1'b1;
    mode_i     <= op;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [ITEM_WIDTH-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // Bias 0 leans to pushes, 1 to pops, 2 is even.
  function automatic mode_e pick_mode(int bias);
    int roll;
    roll = $urandom_range(0, 99);
    case (bias)
      0: begin
        if (roll < 70) return MODE_PUSH_RIGHT;
        if (roll < 82) return MODE_POP_LEFT;
        if (roll < 94) return MODE_POP_RIGHT;
        return MODE_NOP;
      end
      1: begin
        if (roll < 20) return MODE_PUSH_RIGHT;
        if (roll < 55) return MODE_POP_LEFT;
        if (roll < 90) return MODE_POP_RIGHT;
        return MODE_NOP;
      end
      default: begin
        if (roll < 40) return MODE_PUSH_RIGHT;
        if (roll < 65) return MODE_POP_LEFT;
        if (roll < 90) return MODE_POP_RIGHT;
        return MODE_NOP;
      end
    endcase
  endfunction

  initial begin
    int sent;
    int burst_len;
    int gap_len;
    int bias;
    sb = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    mode_i     <= MODE_NOP;
    value_i    <= '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty pops, extremes, wrap through a full queue, push on full.
    offer_item(MODE_POP_LEFT, 32'h0000_0000);
    offer_item(MODE_POP_RIGHT, 32'hFFFF_FFFF);
    offer_item(MODE_NOP, 32'hA5A5_A5A5);
    offer_item(MODE_PUSH_RIGHT, 32'h0000_0000);
    offer_item(MODE_PUSH_RIGHT, 32'hFFFF_FFFF);
    offer_item(MODE_POP_RIGHT, 32'h1234_5678);
    offer_item(MODE_POP_LEFT, 32'h0000_0000);
    for (int i = 0; i < DEPTH; i++) begin
      offer_item(MODE_PUSH_RIGHT, (i[0]) ? 32'hFFFF_FFF0 | i : 32'h1000_0000 + i);
    end
    offer_item(MODE_PUSH_RIGHT, 32'hDEAD_BEEF);
    offer_item(MODE_POP_LEFT, 32'h0000_0000);

    sent = 0;
    while (sent < NUM_RANDOM) begin
      burst_len = $urandom_range(1, 40);
      bias      = $urandom_range(0, 2);
      for (int i = 0; i < burst_len && sent < NUM_RANDOM; i++) begin
        offer_item(pick_mode(bias), pick_value());
        sent++;
      end
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len > 0) begin
        // Drop valid and scramble the payload while idle.
        in_valid_i <= 1'b0;
        mode_i     <= 2'($urandom_range(0, 3));
        value_i    <= $urandom;
        repeat (gap_len) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
